[hw/rtl/ssq_pkg.sv]
// ----------------------------------------------------------------------------
// ssq_pkg
// Shared types and constants of the stable sorted priority queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssq_pkg;

  localparam int Depth  = 16;
  localparam int IdxW   = $clog2(Depth);
  localparam int CntW   = $clog2(Depth + 1);
  localparam int KeyW   = 32;
  localparam int TagW   = 16;
  localparam int OccW   = 5;
  localparam int EntryW = KeyW + TagW;

  localparam logic ModeInsert = 1'b0;
  localparam logic ModePop    = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SCAN,
    S_INS_HEAD,
    S_POP_HEAD,
    S_POP_SHIFT,
    S_DONE
  } seq_state_e;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [TagW-1:0] tag;
  } entry_t;

  typedef struct packed {
    status_e         status;
    logic [KeyW-1:0] key;
    logic [TagW-1:0] tag;
    logic [OccW-1:0] occupancy;
  } res_t;

endpackage

[hw/rtl/ssq_in_if.sv]
// ----------------------------------------------------------------------------
// ssq_in_if
// Request channel: mode, key and tag with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ssq_in_if;
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [ssq_pkg::KeyW-1:0] key;
  logic [ssq_pkg::TagW-1:0] tag;

  modport source (output valid, output mode, output key, output tag, input ready);
  modport sink   (input valid, input mode, input key, input tag, output ready);
endinterface

[hw/rtl/ssq_out_if.sv]
// ----------------------------------------------------------------------------
// ssq_out_if
// Result channel: status, popped entry and occupancy with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ssq_out_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic [ssq_pkg::KeyW-1:0] out_key;
  logic [ssq_pkg::TagW-1:0] out_tag;
  logic [ssq_pkg::OccW-1:0] occupancy;

  modport source (output valid, output status, output out_key, output out_tag,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input out_key, input out_tag,
                  input occupancy, output ready);
endinterface

[hw/rtl/ssq_ram.sv]
// ----------------------------------------------------------------------------
// ssq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssq_ram #(
  parameter int Width = 48,
  parameter int Depth = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

[hw/rtl/ssq_seq.sv]
// ----------------------------------------------------------------------------
// ssq_seq
// Sequencer: walks the entry RAM one slot a cycle through one key comparator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssq_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  ssq_in_if.sink                       in_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output ssq_pkg::res_t                res_o,
  output logic                         we_o,
  output logic [ssq_pkg::IdxW-1:0]     waddr_o,
  output logic [ssq_pkg::EntryW-1:0]   wdata_o,
  output logic [ssq_pkg::IdxW-1:0]     raddr_o,
  input  logic [ssq_pkg::EntryW-1:0]   rdata_i
);

  ssq_pkg::seq_state_e      state_q, state_d;
  logic [ssq_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [ssq_pkg::IdxW-1:0] ptr_q, ptr_d;
  ssq_pkg::entry_t          new_q, new_d;
  ssq_pkg::entry_t          pop_q, pop_d;
  ssq_pkg::status_e         stat_q, stat_d;
  ssq_pkg::entry_t          rd_entry;
  logic                     cmp_gt;

  assign rd_entry = ssq_pkg::entry_t'(rdata_i);
  // single comparator: stored key strictly above the new key
  assign cmp_gt   = rd_entry.key > new_q.key;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssq_pkg::S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    new_q  <= new_d;
    pop_q  <= pop_d;
    stat_q <= stat_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    new_d       = new_q;
    pop_d       = pop_q;
    stat_d      = stat_q;
    in_i.ready  = 1'b0;
    res_valid_o = 1'b0;
    we_o        = 1'b0;
    waddr_o     = ptr_q;
    wdata_o     = new_q;
    raddr_o     = ptr_q;
    case (state_q)
      ssq_pkg::S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          new_d  = '{key: in_i.key, tag: in_i.tag};
          pop_d  = '0;
          stat_d = ssq_pkg::ST_DONE;
          if (in_i.mode == ssq_pkg::ModePop) begin
            if (cnt_q == '0) begin
              stat_d  = ssq_pkg::ST_EMPTY;
              state_d = ssq_pkg::S_DONE;
            end else begin
              raddr_o = '0;
              state_d = ssq_pkg::S_POP_HEAD;
            end
          end else if (cnt_q == ssq_pkg::CntW'(ssq_pkg::Depth)) begin
            stat_d  = ssq_pkg::ST_FULL;
            state_d = ssq_pkg::S_DONE;
          end else if (cnt_q == '0) begin
            we_o    = 1'b1;
            waddr_o = '0;
            wdata_o = {in_i.key, in_i.tag};
            cnt_d   = cnt_q + 1'b1;
            state_d = ssq_pkg::S_DONE;
          end else begin
            // scan from the tail toward the head
            ptr_d   = ssq_pkg::IdxW'(cnt_q - 1'b1);
            raddr_o = ssq_pkg::IdxW'(cnt_q - 1'b1);
            state_d = ssq_pkg::S_INS_SCAN;
          end
        end
      end
      ssq_pkg::S_INS_SCAN: begin
        we_o    = 1'b1;
        waddr_o = ptr_q + 1'b1;
        if (cmp_gt) begin
          // larger key moves one slot back
          wdata_o = rdata_i;
          if (ptr_q == '0) begin
            state_d = ssq_pkg::S_INS_HEAD;
          end else begin
            ptr_d   = ptr_q - 1'b1;
            raddr_o = ptr_q - 1'b1;
          end
        end else begin
          wdata_o = new_q;
          cnt_d   = cnt_q + 1'b1;
          state_d = ssq_pkg::S_DONE;
        end
      end
      ssq_pkg::S_INS_HEAD: begin
        we_o    = 1'b1;
        waddr_o = '0;
        wdata_o = new_q;
        cnt_d   = cnt_q + 1'b1;
        state_d = ssq_pkg::S_DONE;
      end
      ssq_pkg::S_POP_HEAD: begin
        pop_d = rd_entry;
        if (cnt_q == ssq_pkg::CntW'(1)) begin
          cnt_d   = cnt_q - 1'b1;
          state_d = ssq_pkg::S_DONE;
        end else begin
          ptr_d   = ssq_pkg::IdxW'(1);
          raddr_o = ssq_pkg::IdxW'(1);
          state_d = ssq_pkg::S_POP_SHIFT;
        end
      end
      ssq_pkg::S_POP_SHIFT: begin
        // slide each entry one slot toward the head
        we_o    = 1'b1;
        waddr_o = ptr_q - 1'b1;
        wdata_o = rdata_i;
        if (ptr_q == ssq_pkg::IdxW'(cnt_q - 1'b1)) begin
          cnt_d   = cnt_q - 1'b1;
          state_d = ssq_pkg::S_DONE;
        end else begin
          ptr_d   = ptr_q + 1'b1;
          raddr_o = ptr_q + 1'b1;
        end
      end
      ssq_pkg::S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ssq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ssq_pkg::S_IDLE;
      end
    endcase
  end

  assign res_o = '{status:    stat_q,
                   key:       pop_q.key,
                   tag:       pop_q.tag,
                   occupancy: ssq_pkg::OccW'(cnt_q)};

endmodule

[hw/rtl/stable_sorted_priority_queue.sv]
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue
// Bounded queue kept in ascending key order, equal keys first in, first out.
// ----------------------------------------------------------------------------
// an insert scans from the tail toward the head, moving each larger key one slot
// back; a pop takes the head entry and slides the rest toward the head; a refused
// insert or pop leaves the entry ram untouched
// one beat in flight at a time; the single read port of the entry ram sets
// the pace, one slot compared or moved per cycle
// reset clears the fill count at once; the entry ram holds no reset value
`timescale 1ns / 1ps

module stable_sorted_priority_queue (
  input  logic      clk_i,
  input  logic      rst_ni,
  ssq_in_if.sink    in_i,
  ssq_out_if.source out_o
);

  // sequencer to output register
  logic          res_valid;
  logic          res_ready;
  ssq_pkg::res_t res;

  // entry ram ports
  logic                       ram_we;
  logic [ssq_pkg::IdxW-1:0]   ram_waddr;
  logic [ssq_pkg::EntryW-1:0] ram_wdata;
  logic [ssq_pkg::IdxW-1:0]   ram_raddr;
  logic [ssq_pkg::EntryW-1:0] ram_rdata;

  // output register
  logic          out_valid_q, out_valid_d;
  ssq_pkg::res_t out_q, out_d;

  ssq_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .we_o        (ram_we),
    .waddr_o     (ram_waddr),
    .wdata_o     (ram_wdata),
    .raddr_o     (ram_raddr),
    .rdata_i     (ram_rdata)
  );

  ssq_ram #(
    .Width (ssq_pkg::EntryW),
    .Depth (ssq_pkg::Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // the result register takes a new beat when empty or drained this cycle
  assign res_ready = !out_valid_q || out_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = out_q.status;
  assign out_o.out_key   = out_q.key;
  assign out_o.out_tag   = out_q.tag;
  assign out_o.occupancy = out_q.occupancy;

`ifndef SYNTHESIS
  // a request beat closes the request side until its result enters the output register
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("request taken while an item is in work");

  // a full refusal always reports a full queue
  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == ssq_pkg::ST_FULL) |->
      (out_q.occupancy == ssq_pkg::OccW'(ssq_pkg::Depth)))
    else $error("full status with occupancy below depth");

  // an empty pop reports nothing held and no entry
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == ssq_pkg::ST_EMPTY) |->
      (out_q.occupancy == '0 && out_q.key == '0 && out_q.tag == '0))
    else $error("empty status with held entries or data");

  // the sequencer never offers a result beat while it is taking a request
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_valid && in_i.ready))
    else $error("result and request overlap");
`endif

endmodule
